@@ src/ipf_pkg.sv @@
package ipf_pkg;

  // Store geometry is fixed by the 16-bit pixel address.
  localparam int ADDR_W      = 16;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int PIX_W       = 32;

  // Signed width of a source row or column before the border check.
  localparam int POS_W = 12;

  // Default limits for the top-level parameters.
  localparam int DEF_MAX_DIM      = 64;
  localparam int DEF_MAX_CHANNELS = 16;
  localparam int DEF_MAX_KERNEL   = 7;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD           = 3'd5;

  // Opcodes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] pixel_address;
    logic [PIX_W-1:0]  pixel_value;
    logic [3:0]        channel;
    logic [2:0]        kernel_row;
    logic [2:0]        kernel_col;
    logic [6:0]        out_row;
    logic [6:0]        out_col;
  } ipf_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             is_padding;
    logic             bad_request;
  } ipf_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_ADDR,
    ST_READ,
    ST_RESP
  } ipf_state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic addr;
    logic read;
    logic respond;
  } ipf_cmd_t;

  typedef struct packed {
    logic is_write;
  } ipf_sts_t;

endpackage

@@ src/im2col_patch_fetch_core.sv @@
// im2col patch fetch core.
// A request is taken on a rising edge with start high and busy low; in_data
// carries the opcode and fields. A write puts pixel_value into the image store
// at pixel_address. A fetch returns one im2col element: the source pixel at
// out*stride + kernel offset - pad, zero with is_padding where that lands in
// the border, zero with bad_request where an index lies off the kernel, the
// channels or the output grid.
// Each request produces one result, shown on out_data for exactly one cycle
// while out_valid is high. The receiver cannot stall, so no result is held.
// A fetch result appears after the calculate, address and store read states, a
// write result straight after the calculate state.
// A fetch passes calculate, address, store read, respond and idle before another
// request is accepted, set by the multiply chain of the address followed by the
// registered read port of the store. A write skips address and store read.
// The configuration port is always ready; write it only while the core is idle.
// Synchronous reset returns the sequencer to idle and loads the register
// defaults; the image store is not cleared and must be written before it is read.
module im2col_patch_fetch_core import ipf_pkg::*; #(
  parameter int MAX_DIM      = DEF_MAX_DIM,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_KERNEL   = DEF_MAX_KERNEL
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  ipf_in_t               in_data,
  output logic                  out_valid,
  output ipf_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ipf_cmd_t cmd;
  ipf_sts_t sts;

  assign cfg_ready = 1'b1;
  assign out_valid = cmd.respond;

  ipf_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .busy (busy),
    .cmd  (cmd)
  );

  ipf_datapath #(
    .MAX_DIM     (MAX_DIM),
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_KERNEL  (MAX_KERNEL)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("core not busy after accepting a request");

  a_resp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid)
    else $error("core did not return to idle after a result");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.is_padding && out_data.bad_request))
    else $error("padding and bad request flagged together");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.is_padding || out_data.bad_request)) |->
      (out_data.value == '0))
    else $error("flagged result carries a nonzero value");

endmodule

@@ src/ipf_ram.sv @@
module ipf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/ipf_ctrl.sv @@
module ipf_ctrl import ipf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  ipf_sts_t sts,
  output logic     busy,
  output ipf_cmd_t cmd
);

  ipf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_CALC;
      ST_CALC: state_nxt = sts.is_write ? ST_RESP : ST_ADDR;
      ST_ADDR: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_RESP;
      ST_RESP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CALC: cmd.calc    = 1'b1;
      ST_ADDR: cmd.addr    = 1'b1;
      ST_READ: cmd.read    = 1'b1;
      ST_RESP: cmd.respond = 1'b1;
      default: busy = 1'b0;
    endcase
  end

endmodule

@@ src/ipf_datapath.sv @@
module ipf_datapath import ipf_pkg::*; #(
  parameter int MAX_DIM      = DEF_MAX_DIM,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_KERNEL   = DEF_MAX_KERNEL
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ipf_in_t               in_data,
  input  ipf_cmd_t              cmd,
  output ipf_sts_t              sts,
  output ipf_out_t              out_data
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
  localparam int KER_W = $clog2(MAX_KERNEL + 1);

  logic [6:0] cfg_w_r, cfg_h_r;
  logic [4:0] cfg_c_r;
  logic [2:0] cfg_k_r, cfg_s_r;
  logic [1:0] cfg_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= 7'd64;
      cfg_h_r <= 7'd64;
      cfg_c_r <= 5'd3;
      cfg_k_r <= 3'd3;
      cfg_s_r <= 3'd1;
      cfg_p_r <= 2'd0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:   cfg_w_r <= cfg_data;
        CFG_IMAGE_HEIGHT:  cfg_h_r <= cfg_data;
        CFG_CHANNEL_COUNT: cfg_c_r <= cfg_data[4:0];
        CFG_KERNEL_SIZE:   cfg_k_r <= cfg_data[2:0];
        CFG_STRIDE:        cfg_s_r <= cfg_data[2:0];
        CFG_PAD:           cfg_p_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Effective settings: saturate to the build limits, zero stride acts as one.
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [CH_W-1:0]  c_eff;
  logic [KER_W-1:0] k_eff;
  logic [2:0]       s_eff;

  assign w_eff = (16'(cfg_w_r) > 16'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(cfg_w_r);
  assign h_eff = (16'(cfg_h_r) > 16'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(cfg_h_r);
  assign c_eff = (16'(cfg_c_r) > 16'(MAX_CHANNELS)) ? CH_W'(MAX_CHANNELS) : CH_W'(cfg_c_r);
  assign k_eff = (16'(cfg_k_r) > 16'(MAX_KERNEL)) ? KER_W'(MAX_KERNEL) : KER_W'(cfg_k_r);
  assign s_eff = (cfg_s_r == 3'd0) ? 3'd1 : cfg_s_r;

  ipf_in_t req_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
  end

  assign sts.is_write = (req_r.opcode == OP_WRITE);

  // Calculation stage: source position, range checks, channel base.
  logic [9:0]              orow_s, ocol_s;
  logic signed [POS_W-1:0] row_pos, col_pos;
  logic [POS_W-1:0]        row_need, col_need, row_span, col_span;
  logic                    bad, padding;
  logic [ADDR_W-1:0]       chh;

  always_comb begin
    orow_s = 10'(req_r.out_row * s_eff);
    ocol_s = 10'(req_r.out_col * s_eff);
    row_pos = $signed(12'(orow_s) + 12'(req_r.kernel_row) - 12'(cfg_p_r));
    col_pos = $signed(12'(ocol_s) + 12'(req_r.kernel_col) - 12'(cfg_p_r));
    // An output index lies on the grid when index*stride + kernel fits the padded span.
    row_need = 12'(orow_s) + 12'(k_eff);
    col_need = 12'(ocol_s) + 12'(k_eff);
    row_span = 12'(h_eff) + {9'd0, cfg_p_r, 1'b0};
    col_span = 12'(w_eff) + {9'd0, cfg_p_r, 1'b0};
    bad = (16'(req_r.channel) >= 16'(c_eff)) ||
          (16'(req_r.kernel_row) >= 16'(k_eff)) ||
          (16'(req_r.kernel_col) >= 16'(k_eff)) ||
          (row_need > row_span) || (col_need > col_span);
    padding = row_pos[POS_W-1] || col_pos[POS_W-1] ||
              (row_pos >= $signed({1'b0, 11'(h_eff)})) ||
              (col_pos >= $signed({1'b0, 11'(w_eff)}));
    chh = ADDR_W'(16'(req_r.channel) * 16'(h_eff));
  end

  logic              wr_r, bad_r, pad_r;
  logic [ADDR_W-1:0] row_r, col_r, chh_r, addr_r;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      wr_r  <= sts.is_write;
      bad_r <= !sts.is_write && bad;
      pad_r <= !sts.is_write && !bad && padding;
      row_r <= ADDR_W'(row_pos[POS_W-2:0]);
      col_r <= ADDR_W'(col_pos[POS_W-2:0]);
      chh_r <= chh;
    end
  end

  // Address stage; the address wraps to the store width.
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] addr_nxt;

  always_comb begin
    base     = chh_r + row_r;
    addr_nxt = ADDR_W'(base * ADDR_W'(w_eff)) + col_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.addr) begin
      addr_r <= addr_nxt;
    end
  end

  logic [PIX_W-1:0] rdata;

  ipf_ram #(
    .WIDTH(PIX_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.calc && sts.is_write),
    .waddr(req_r.pixel_address),
    .wdata(req_r.pixel_value),
    .re   (cmd.read),
    .raddr(addr_r),
    .rdata(rdata)
  );

  always_comb begin
    out_data.value       = (wr_r || bad_r || pad_r) ? '0 : rdata;
    out_data.is_padding  = pad_r;
    out_data.bad_request = bad_r;
  end

endmodule

@@ tb/tb_im2col_patch_fetch_core.sv @@
module tb_im2col_patch_fetch_core import ipf_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;
  localparam int IDLE_PERCENT = 27;
  localparam int ITEMS_PER_PHASE = 100;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = 3'd7;

  typedef enum logic [1:0] {
    SRC_BAD,
    SRC_PAD,
    SRC_PIXEL
  } src_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  ipf_in_t in_data = '0;
  logic out_valid;
  ipf_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  im2col_patch_fetch_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the configuration registers, at their reset values.
  logic [6:0] width_reg = 7'd64;
  logic [6:0] height_reg = 7'd64;
  logic [4:0] chan_reg = 5'd3;
  logic [2:0] kernel_reg = 3'd3;
  logic [2:0] stride_reg = 3'd1;
  logic [1:0] pad_reg = 2'd0;

  // Effective geometry after saturation, shared by prediction and stimulus.
  int img_w, img_h, chan_n, kern_n, step_n, border_n, grid_rows, grid_cols;

  logic [PIX_W-1:0] image_copy [STORE_DEPTH];
  bit written_map [STORE_DEPTH];

  ipf_in_t pending_requests [$];
  ipf_out_t elements_due [$];

  logic taken = 1'b0;
  logic steady = 1'b0;
  int gap_left = 0;
  int mismatches = 0;
  int cycle_count = 0;

  int unsigned geometry_plan [9][6] = '{
    '{64, 64, 16, 7, 4, 3},
    '{127, 127, 31, 7, 0, 3},
    '{1, 1, 1, 1, 1, 0},
    '{0, 5, 2, 3, 2, 2},
    '{9, 0, 4, 2, 3, 1},
    '{8, 8, 0, 3, 1, 1},
    '{8, 8, 2, 0, 1, 1},
    '{64, 64, 16, 1, 1, 0},
    '{3, 2, 1, 7, 1, 3}
  };

  function automatic int grid_len(input int dim);
    int span;
    span = dim + 2 * border_n;
    if (span < kern_n) return 0;
    return (span - kern_n) / step_n + 1;
  endfunction

  function automatic void refresh_geometry();
    img_w = (width_reg > DEF_MAX_DIM) ? DEF_MAX_DIM : int'(width_reg);
    img_h = (height_reg > DEF_MAX_DIM) ? DEF_MAX_DIM : int'(height_reg);
    chan_n = (chan_reg > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : int'(chan_reg);
    kern_n = (kernel_reg > DEF_MAX_KERNEL) ? DEF_MAX_KERNEL : int'(kernel_reg);
    step_n = (stride_reg == 3'd0) ? 1 : int'(stride_reg);
    border_n = int'(pad_reg);
    grid_rows = grid_len(img_h);
    grid_cols = grid_len(img_w);
  endfunction

  // Classifies a fetch and, for an in-image position, gives its store address.
  function automatic src_kind_t locate_source(input ipf_in_t r, output logic [ADDR_W-1:0] addr);
    int ch, kr, kc, orow, ocol, row, col;
    ch = int'(r.channel);
    kr = int'(r.kernel_row);
    kc = int'(r.kernel_col);
    orow = int'(r.out_row);
    ocol = int'(r.out_col);
    addr = '0;
    if (ch >= chan_n || kr >= kern_n || kc >= kern_n || orow >= grid_rows ||
        ocol >= grid_cols) return SRC_BAD;
    row = orow * step_n + kr - border_n;
    col = ocol * step_n + kc - border_n;
    if (row < 0 || row >= img_h || col < 0 || col >= img_w) return SRC_PAD;
    addr = ADDR_W'((ch * img_h + row) * img_w + col);
    return SRC_PIXEL;
  endfunction

  function automatic ipf_out_t lower_element(input ipf_in_t r);
    ipf_out_t res;
    logic [ADDR_W-1:0] addr;
    res = '0;
    if (r.opcode == OP_WRITE) begin
      image_copy[r.pixel_address] = r.pixel_value;
    end else begin
      case (locate_source(r, addr))
        SRC_BAD: res.bad_request = 1'b1;
        SRC_PAD: res.is_padding = 1'b1;
        default: res.value = image_copy[addr];
      endcase
    end
    return res;
  endfunction

  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic ipf_in_t random_request();
    ipf_in_t r;
    r.opcode = OP_FETCH;
    r.pixel_address = ADDR_W'($urandom());
    r.pixel_value = $urandom();
    r.channel = 4'($urandom());
    r.kernel_row = 3'($urandom());
    r.kernel_col = 3'($urandom());
    r.out_row = 7'($urandom());
    r.out_col = 7'($urandom());
    return r;
  endfunction

  function automatic void push_write(input logic [ADDR_W-1:0] addr, input logic [PIX_W-1:0] val);
    ipf_in_t r;
    r = random_request();
    r.opcode = OP_WRITE;
    r.pixel_address = addr;
    r.pixel_value = val;
    written_map[addr] = 1'b1;
    pending_requests.push_back(r);
  endfunction

  // A fetch that would land on a never-written word gets that word written first.
  function automatic void push_fetch(input ipf_in_t r);
    logic [ADDR_W-1:0] addr;
    r.opcode = OP_FETCH;
    if (locate_source(r, addr) == SRC_PIXEL && !written_map[addr])
      push_write(addr, $urandom());
    pending_requests.push_back(r);
  endfunction

  function automatic void fetch_at(input int ch, input int kr, input int kc, input int orow,
                                   input int ocol);
    ipf_in_t r;
    r = random_request();
    r.channel = 4'(ch);
    r.kernel_row = 3'(kr);
    r.kernel_col = 3'(kc);
    r.out_row = 7'(orow);
    r.out_col = 7'(ocol);
    push_fetch(r);
  endfunction

  function automatic void random_items(input int count);
    int pick;
    int span;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      span = chan_n * img_h * img_w;
      if (pick < 25) begin
        if (pick < 15 && span > 0) begin
          push_write(ADDR_W'($urandom_range(span - 1)), $urandom());
        end else begin
          push_write(ADDR_W'($urandom()), $urandom());
        end
      end else if (pick < 85 && chan_n > 0 && kern_n > 0 && grid_rows > 0 && grid_cols > 0) begin
        fetch_at($urandom_range(chan_n - 1), $urandom_range(kern_n - 1),
                 $urandom_range(kern_n - 1), $urandom_range(grid_rows - 1),
                 $urandom_range(grid_cols - 1));
      end else begin
        push_fetch(random_request());
      end
    end
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_geometry(input int unsigned w, input int unsigned h,
                                  input int unsigned c, input int unsigned k,
                                  input int unsigned s, input int unsigned p);
    cfg_write(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    cfg_write(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    cfg_write(CFG_CHANNEL_COUNT, CFG_DATA_W'(c));
    cfg_write(CFG_KERNEL_SIZE, CFG_DATA_W'(k));
    cfg_write(CFG_STRIDE, CFG_DATA_W'(s));
    cfg_write(CFG_PAD, CFG_DATA_W'(p));
    cfg_write(CFG_IDX_UNUSED_LO, CFG_DATA_W'($urandom()));
    cfg_write(CFG_IDX_UNUSED_HI, CFG_DATA_W'($urandom()));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits for every request to be answered and the sequencer to go idle.
  task automatic wait_idle();
    while (pending_requests.size() != 0 || start || elements_due.size() != 0 || busy)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_requests.size() == 0) begin
        start <= 1'b0;
      end else if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
        gap_left <= $urandom_range(5);
        start <= 1'b0;
      end else begin
        in_data <= pending_requests.pop_front();
        start <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    ipf_out_t want;
    if (!rst_n) begin
      taken <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (out_valid) begin
        if (elements_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: value=%h pad=%b bad=%b",
                                  out_data.value, out_data.is_padding, out_data.bad_request));
        end else begin
          want = elements_due.pop_front();
          if (out_data.value !== want.value || out_data.is_padding !== want.is_padding ||
              out_data.bad_request !== want.bad_request) begin
            flag_mismatch($sformatf(
              "mismatch: expected value=%h pad=%b bad=%b, got value=%h pad=%b bad=%b",
              want.value, want.is_padding, want.bad_request,
              out_data.value, out_data.is_padding, out_data.bad_request));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH: width_reg = cfg_data;
          CFG_IMAGE_HEIGHT: height_reg = cfg_data;
          CFG_CHANNEL_COUNT: chan_reg = cfg_data[4:0];
          CFG_KERNEL_SIZE: kernel_reg = cfg_data[2:0];
          CFG_STRIDE: stride_reg = cfg_data[2:0];
          CFG_PAD: pad_reg = cfg_data[1:0];
          default: ;
        endcase
        refresh_geometry();
      end
      if (start && !busy) elements_due.push_back(lower_element(in_data));
    end
  end

  initial begin
    refresh_geometry();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset geometry: 64x64, three channels, 3x3 kernel, unit stride, no border.
    steady = 1'b1;
    push_write(16'h0000, 32'h0000_0000);
    push_write(16'hFFFF, 32'hFFFF_FFFF);
    push_write(16'h8000, 32'hA5A5_5A5A);
    fetch_at(0, 0, 0, 0, 0);
    fetch_at(2, 2, 2, 61, 61);
    fetch_at(3, 0, 0, 0, 0);
    fetch_at(15, 0, 0, 0, 0);
    fetch_at(0, 3, 0, 0, 0);
    fetch_at(0, 0, 7, 0, 0);
    fetch_at(0, 0, 0, 62, 0);
    fetch_at(0, 0, 0, 0, 127);
    random_items(130);
    wait_idle();
    steady = 1'b0;

    for (int i = 0; i < 9; i++) begin
      program_geometry(geometry_plan[i][0], geometry_plan[i][1], geometry_plan[i][2],
                       geometry_plan[i][3], geometry_plan[i][4], geometry_plan[i][5]);
      if (i == 0) begin
        // Wide border with a 7x7 kernel: the first two fall in the zero border.
        fetch_at(0, 0, 0, 0, 0);
        fetch_at(1, 6, 0, 0, 0);
        fetch_at(15, 6, 6, 15, 15);
        fetch_at(0, 0, 6, 15, 15);
        fetch_at(0, 0, 0, 16, 0);
      end
      random_items(ITEMS_PER_PHASE);
      wait_idle();
    end

    for (int i = 0; i < 3; i++) begin
      program_geometry($urandom_range(127), $urandom_range(127), $urandom_range(31),
                       $urandom_range(127), $urandom_range(127), $urandom_range(127));
      random_items(ITEMS_PER_PHASE);
      wait_idle();
    end

    if (mismatches == 0 && elements_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
